/* hw/rtl/source_text_tokenizer_unit_assert.svh */
// Assertion macros used by the tokenizer port checker
`ifndef SOURCE_TEXT_TOKENIZER_UNIT_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_UNIT_ASSERT_SVH

// Clocked check, switched off while reset is high
`define STT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Clocked check that also holds across reset
`define STT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

/* hw/rtl/stt_pkg.sv */
// Shared types, constants and tables of the source text tokenizer
package stt_pkg;

   localparam int LINE_BITS      = 16;
   localparam int COLUMN_BITS    = 12;
   localparam int KEYWORD_COUNT  = 5;
   localparam int LEN_BITS       = 12;
   localparam int VALUE_BITS     = 32;
   localparam int KIND_BITS      = 5;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   localparam logic [KEYWORD_COUNT-1:0] KW_ALL = {KEYWORD_COUNT{1'b1}};

   // Token kinds
   localparam logic [KIND_BITS-1:0] KIND_NUMBER = 5'd0;
   localparam logic [KIND_BITS-1:0] KIND_IDENT  = 5'd1;
   localparam logic [KIND_BITS-1:0] KIND_FUNC   = 5'd2;
   localparam logic [KIND_BITS-1:0] KIND_PLUS   = 5'd7;
   localparam logic [KIND_BITS-1:0] KIND_MINUS  = 5'd8;
   localparam logic [KIND_BITS-1:0] KIND_STAR   = 5'd9;
   localparam logic [KIND_BITS-1:0] KIND_DIV    = 5'd10;
   localparam logic [KIND_BITS-1:0] KIND_LPAREN = 5'd11;
   localparam logic [KIND_BITS-1:0] KIND_RPAREN = 5'd12;
   localparam logic [KIND_BITS-1:0] KIND_LBRACE = 5'd13;
   localparam logic [KIND_BITS-1:0] KIND_RBRACE = 5'd14;
   localparam logic [KIND_BITS-1:0] KIND_SEMI   = 5'd15;
   localparam logic [KIND_BITS-1:0] KIND_COMMA  = 5'd16;
   localparam logic [KIND_BITS-1:0] KIND_ASSIGN = 5'd17;
   localparam logic [KIND_BITS-1:0] KIND_EQ     = 5'd18;
   localparam logic [KIND_BITS-1:0] KIND_NE     = 5'd19;
   localparam logic [KIND_BITS-1:0] KIND_NOT    = 5'd20;
   localparam logic [KIND_BITS-1:0] KIND_ANDAND = 5'd21;
   localparam logic [KIND_BITS-1:0] KIND_OROR   = 5'd22;
   localparam logic [KIND_BITS-1:0] KIND_LT     = 5'd23;
   localparam logic [KIND_BITS-1:0] KIND_LE     = 5'd24;
   localparam logic [KIND_BITS-1:0] KIND_GT     = 5'd25;
   localparam logic [KIND_BITS-1:0] KIND_GE     = 5'd26;
   localparam logic [KIND_BITS-1:0] KIND_ERROR  = 5'd27;
   localparam logic [KIND_BITS-1:0] KIND_END    = 5'd28;

   // Keyword spellings, zero padded; unused rows are empty
   localparam logic [7:0] KW_TEXT [8][8] = '{
      '{"f", "u", "n", "c", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
      '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };
   localparam logic [2:0] KW_LEN [8] = '{3'd4, 3'd2, 3'd4, 3'd5, 3'd6, 3'd0, 3'd0, 3'd0};

   // Scanner modes
   typedef enum logic [7:0] {
      MODE_IDLE       = 8'b0000_0001,
      MODE_NUMBER     = 8'b0000_0010,
      MODE_IDENT      = 8'b0000_0100,
      MODE_SLASH      = 8'b0000_1000,
      MODE_LINE       = 8'b0001_0000,
      MODE_BLOCK      = 8'b0010_0000,
      MODE_BLOCK_STAR = 8'b0100_0000,
      MODE_OPER       = 8'b1000_0000
   } mode_type;

   // Operator character waiting for a possible second character
   typedef enum logic [2:0] {
      OP_ASSIGN = 3'd0,
      OP_BANG   = 3'd1,
      OP_AMP    = 3'd2,
      OP_BAR    = 3'd3,
      OP_LT     = 3'd4,
      OP_GT     = 3'd5
   } op_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]   kind;
      logic [LINE_BITS-1:0]   line;
      logic [COLUMN_BITS-1:0] column;
      logic [LEN_BITS-1:0]    length;
      logic [VALUE_BITS-1:0]  value;
      logic                   last;
   } tok_type;

   // All tokens caused by one input item
   typedef struct packed {
      tok_type first;
      tok_type second;
      logic    two;
   } group_type;

   typedef struct packed {
      logic      push;
      group_type grp;
   } push_type;

endpackage

/* hw/rtl/stt_req_if.sv */
// Input channel: one source byte or end marker per transfer
interface stt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_of_text;

   modport source (output valid, char_byte, end_of_text, input ready);
   modport sink (input valid, char_byte, end_of_text, output ready);
endinterface

/* hw/rtl/stt_rsp_if.sv */
// Result channel: one token per transfer
interface stt_rsp_if;
   import stt_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [KIND_BITS-1:0]   token_kind;
   logic [LINE_BITS-1:0]   start_line;
   logic [COLUMN_BITS-1:0] start_column;
   logic [LEN_BITS-1:0]    token_length;
   logic [VALUE_BITS-1:0]  number_value;
   logic                   last_of_run;

   modport source (output valid, token_kind, start_line, start_column, token_length,
                   number_value, last_of_run, input ready);
   modport sink (input valid, token_kind, start_line, start_column, token_length,
                 number_value, last_of_run, output ready);
endinterface

/* hw/rtl/stt_front.sv */
// Scanner front end: takes one byte per cycle while the queue has room and builds the token group it causes
module stt_front (
   input  logic              clock,
   input  logic              reset,
   stt_req_if.sink           req_bus,
   input  logic              q_full,
   output stt_pkg::push_type push_out
);
   import stt_pkg::*;

   localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
   localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
   localparam logic [LEN_BITS-1:0]    LEN_MAX  = '1;

   // Scanner state
   mode_type                 mode_ff, mode_in;
   op_type                   pend_ff, pend_in;
   logic [LINE_BITS-1:0]     line_ff, line_in;
   logic [COLUMN_BITS-1:0]   col_ff, col_in;
   logic [LINE_BITS-1:0]     tok_line_ff, tok_line_in;
   logic [COLUMN_BITS-1:0]   tok_col_ff, tok_col_in;
   logic [LEN_BITS-1:0]      len_ff, len_in;
   logic [VALUE_BITS-1:0]    acc_ff, acc_in;
   logic [KEYWORD_COUNT-1:0] cand_ff, cand_in;
   logic                     ended_ff, ended_in;

   logic                     take;
   logic [7:0]               c;
   logic                     c_digit, c_alpha, c_space;
   logic [LEN_BITS-1:0]      len_inc;
   logic [VALUE_BITS+3:0]    acc_wide;
   logic [VALUE_BITS-1:0]    acc_next;

   // Start classification
   mode_type                 st_mode;
   op_type                   st_op;
   logic                     st_emit;
   logic [KIND_BITS-1:0]     st_kind;

   // Pending token, single operator and pair
   logic                     fl_emits;
   logic [KIND_BITS-1:0]     fl_kind;
   logic [KIND_BITS-1:0]     id_kind;
   logic [KIND_BITS-1:0]     op1_kind;
   logic [KIND_BITS-1:0]     op2_kind;
   logic                     op2_hit;

   logic                     do_flush, do_start;
   tok_type                  fl_tok, sec_tok;
   logic                     sec_valid;

   function automatic logic [KEYWORD_COUNT-1:0] kw_filter(
      input logic [KEYWORD_COUNT-1:0] cand,
      input logic [LEN_BITS-1:0]      pos,
      input logic [7:0]               ch
   );
      logic [KEYWORD_COUNT-1:0] keep;
      keep = '0;
      for (int k = 0; k < KEYWORD_COUNT; k++) begin
         if (cand[k] && (pos < LEN_BITS'(KW_LEN[k])) && (KW_TEXT[k][pos[2:0]] == ch)) begin
            keep[k] = 1'b1;
         end
      end
      return keep;
   endfunction

   assign req_bus.ready = !q_full;
   assign take          = req_bus.valid && req_bus.ready;
   assign c             = req_bus.char_byte;

   // Character classes
   assign c_digit = (c >= "0") && (c <= "9");
   assign c_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   assign c_space = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));

   // Saturating length and decimal accumulate (x*10 as two shifts)
   assign len_inc  = (len_ff == LEN_MAX) ? len_ff : len_ff + 1'b1;
   assign acc_wide = (VALUE_BITS+4)'({acc_ff, 3'b000}) + (VALUE_BITS+4)'({acc_ff, 1'b0})
                   + (VALUE_BITS+4)'(c[3:0]);
   assign acc_next = (|acc_wide[VALUE_BITS+3:VALUE_BITS]) ? '1 : acc_wide[VALUE_BITS-1:0];

   // What a byte does when it opens a token
   always_comb begin
      st_mode = MODE_IDLE;
      st_op   = OP_ASSIGN;
      st_emit = 1'b0;
      st_kind = KIND_ERROR;
      if (c_space) begin
         st_mode = MODE_IDLE;
      end else if (c_digit) begin
         st_mode = MODE_NUMBER;
      end else if (c_alpha || (c == "_")) begin
         st_mode = MODE_IDENT;
      end else begin
         unique case (c)
            "/": st_mode = MODE_SLASH;
            "=": begin st_mode = MODE_OPER; st_op = OP_ASSIGN; end
            "!": begin st_mode = MODE_OPER; st_op = OP_BANG; end
            "&": begin st_mode = MODE_OPER; st_op = OP_AMP; end
            "|": begin st_mode = MODE_OPER; st_op = OP_BAR; end
            "<": begin st_mode = MODE_OPER; st_op = OP_LT; end
            ">": begin st_mode = MODE_OPER; st_op = OP_GT; end
            "+": begin st_emit = 1'b1; st_kind = KIND_PLUS; end
            "-": begin st_emit = 1'b1; st_kind = KIND_MINUS; end
            "*": begin st_emit = 1'b1; st_kind = KIND_STAR; end
            "(": begin st_emit = 1'b1; st_kind = KIND_LPAREN; end
            ")": begin st_emit = 1'b1; st_kind = KIND_RPAREN; end
            "{": begin st_emit = 1'b1; st_kind = KIND_LBRACE; end
            "}": begin st_emit = 1'b1; st_kind = KIND_RBRACE; end
            ";": begin st_emit = 1'b1; st_kind = KIND_SEMI; end
            ",": begin st_emit = 1'b1; st_kind = KIND_COMMA; end
            default: begin st_emit = 1'b1; st_kind = KIND_ERROR; end
         endcase
      end
   end

   // Identifier or keyword: lowest surviving keyword of matching length wins
   always_comb begin
      id_kind = KIND_IDENT;
      for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
         if (cand_ff[k] && (len_ff == LEN_BITS'(KW_LEN[k]))) begin
            id_kind = KIND_FUNC + KIND_BITS'(k);
         end
      end
   end

   // Operator kinds, alone or paired with the incoming byte
   always_comb begin
      op1_kind = KIND_ERROR;
      op2_kind = KIND_ERROR;
      op2_hit  = 1'b0;
      unique case (pend_ff)
         OP_ASSIGN: begin op1_kind = KIND_ASSIGN; op2_kind = KIND_EQ; op2_hit = (c == "="); end
         OP_BANG:   begin op1_kind = KIND_NOT; op2_kind = KIND_NE; op2_hit = (c == "="); end
         OP_AMP:    begin op2_kind = KIND_ANDAND; op2_hit = (c == "&"); end
         OP_BAR:    begin op2_kind = KIND_OROR; op2_hit = (c == "|"); end
         OP_LT:     begin op1_kind = KIND_LT; op2_kind = KIND_LE; op2_hit = (c == "="); end
         OP_GT:     begin op1_kind = KIND_GT; op2_kind = KIND_GE; op2_hit = (c == "="); end
         default:   begin op1_kind = KIND_ERROR; op2_hit = 1'b0; end
      endcase
   end

   // Token left in the scanner when it is closed
   always_comb begin
      fl_emits = 1'b1;
      fl_kind  = KIND_ERROR;
      unique case (mode_ff)
         MODE_NUMBER: fl_kind = KIND_NUMBER;
         MODE_IDENT:  fl_kind = id_kind;
         MODE_SLASH:  fl_kind = KIND_DIV;
         MODE_OPER:   fl_kind = op1_kind;
         default:     fl_emits = 1'b0;
      endcase
      fl_tok.kind   = fl_kind;
      fl_tok.line   = tok_line_ff;
      fl_tok.column = tok_col_ff;
      fl_tok.length = ((mode_ff == MODE_NUMBER) || (mode_ff == MODE_IDENT)) ? len_ff
                                                                            : LEN_BITS'(1);
      fl_tok.value  = (mode_ff == MODE_NUMBER) ? acc_ff : '0;
      fl_tok.last   = 1'b0;
   end

   // Per-byte scanner step
   always_comb begin
      mode_in     = mode_ff;
      pend_in     = pend_ff;
      line_in     = line_ff;
      col_in      = col_ff;
      tok_line_in = tok_line_ff;
      tok_col_in  = tok_col_ff;
      len_in      = len_ff;
      acc_in      = acc_ff;
      cand_in     = cand_ff;
      ended_in    = ended_ff;
      do_flush    = 1'b0;
      do_start    = 1'b0;
      sec_valid   = 1'b0;
      sec_tok     = '0;

      if (take && !ended_ff) begin
         if (req_bus.end_of_text) begin
            // flush, then the end token at the current position
            do_flush       = 1'b1;
            mode_in        = MODE_IDLE;
            ended_in       = 1'b1;
            sec_valid      = 1'b1;
            sec_tok.kind   = KIND_END;
            sec_tok.line   = line_ff;
            sec_tok.column = col_ff;
         end else begin
            unique case (mode_ff)
               MODE_NUMBER: begin
                  if (c_digit) begin
                     acc_in = acc_next;
                     len_in = len_inc;
                  end else begin
                     do_flush = 1'b1;
                     do_start = 1'b1;
                  end
               end
               MODE_IDENT: begin
                  if (c_alpha || c_digit) begin
                     cand_in = kw_filter(cand_ff, len_ff, c);
                     len_in  = len_inc;
                  end else begin
                     do_flush = 1'b1;
                     do_start = 1'b1;
                  end
               end
               MODE_SLASH: begin
                  if (c == "/") begin
                     mode_in = MODE_LINE;
                  end else if (c == "*") begin
                     mode_in = MODE_BLOCK;
                  end else begin
                     do_flush = 1'b1;
                     do_start = 1'b1;
                  end
               end
               MODE_LINE: begin
                  if (c == 8'h0a) begin
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_BLOCK, MODE_BLOCK_STAR: begin
                  if ((mode_ff == MODE_BLOCK_STAR) && (c == "/")) begin
                     mode_in = MODE_IDLE;
                  end else begin
                     mode_in = (c == "*") ? MODE_BLOCK_STAR : MODE_BLOCK;
                  end
               end
               MODE_OPER: begin
                  if (op2_hit) begin
                     mode_in        = MODE_IDLE;
                     sec_valid      = 1'b1;
                     sec_tok.kind   = op2_kind;
                     sec_tok.line   = tok_line_ff;
                     sec_tok.column = tok_col_ff;
                     sec_tok.length = LEN_BITS'(2);
                  end else begin
                     do_flush = 1'b1;
                     do_start = 1'b1;
                  end
               end
               default: do_start = 1'b1;
            endcase

            // opening a new token
            if (do_start) begin
               mode_in = st_mode;
               if (!c_space) begin
                  tok_line_in = line_ff;
                  tok_col_in  = col_ff;
               end
               if (st_mode == MODE_NUMBER) begin
                  len_in = LEN_BITS'(1);
                  acc_in = VALUE_BITS'(c[3:0]);
               end
               if (st_mode == MODE_IDENT) begin
                  len_in  = LEN_BITS'(1);
                  cand_in = kw_filter(KW_ALL, '0, c);
               end
               if (st_mode == MODE_OPER) begin
                  pend_in = st_op;
               end
               if (st_emit) begin
                  sec_valid      = 1'b1;
                  sec_tok.kind   = st_kind;
                  sec_tok.line   = line_ff;
                  sec_tok.column = col_ff;
                  sec_tok.length = LEN_BITS'(1);
               end
            end

            // position tracking
            if (c == 8'h0a) begin
               line_in = (line_ff == LINE_MAX) ? line_ff : line_ff + 1'b1;
               col_in  = '0;
            end else begin
               col_in = (col_ff == COL_MAX) ? col_ff : col_ff + 1'b1;
            end
         end
      end
   end

   // Pack the group of this byte into a queue entry
   always_comb begin
      push_out = '0;
      if (do_flush && fl_emits) begin
         push_out.push        = 1'b1;
         push_out.grp.first   = fl_tok;
         push_out.grp.second  = sec_tok;
         push_out.grp.two     = sec_valid;
         push_out.grp.first.last  = !sec_valid;
         push_out.grp.second.last = 1'b1;
      end else if (sec_valid) begin
         push_out.push           = 1'b1;
         push_out.grp.first      = sec_tok;
         push_out.grp.first.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         pend_ff     <= OP_ASSIGN;
         line_ff     <= '0;
         col_ff      <= COLUMN_BITS'(1);
         tok_line_ff <= '0;
         tok_col_ff  <= '0;
         len_ff      <= '0;
         acc_ff      <= '0;
         cand_ff     <= KW_ALL;
         ended_ff    <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         pend_ff     <= pend_in;
         line_ff     <= line_in;
         col_ff      <= col_in;
         tok_line_ff <= tok_line_in;
         tok_col_ff  <= tok_col_in;
         len_ff      <= len_in;
         acc_ff      <= acc_in;
         cand_ff     <= cand_in;
         ended_ff    <= ended_in;
      end
   end

endmodule

/* hw/rtl/stt_queue.sv */
// Short queue of token groups between scanner and output stage
module stt_queue (
   input  logic               clock,
   input  logic               reset,
   input  stt_pkg::push_type  push_in,
   output logic               full,
   input  logic               pop,
   output stt_pkg::group_type head,
   output logic               not_empty
);
   import stt_pkg::*;

   group_type                 mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic                      do_push, do_pop;

   assign full      = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   assign do_push = push_in.push && !full;
   assign do_pop  = pop && not_empty;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_in.grp;
      end
   end

endmodule

/* hw/rtl/stt_back.sv */
// Output stage: sends the queued groups one token per transfer
module stt_back (
   input  logic               clock,
   input  logic               reset,
   input  stt_pkg::group_type head,
   input  logic               not_empty,
   output logic               pop,
   stt_rsp_if.source          rsp_bus
);
   import stt_pkg::*;

   tok_type out_ff, out_in;
   logic    out_valid_ff, out_valid_in;
   tok_type hold_ff, hold_in;
   logic    hold_valid_ff, hold_valid_in;
   logic    out_free;

   assign out_free = !out_valid_ff || rsp_bus.ready;
   assign pop      = out_free && !hold_valid_ff && not_empty;

   // Second token of a pair goes out before the next group
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      if (out_free) begin
         if (hold_valid_ff) begin
            out_in        = hold_ff;
            out_valid_in  = 1'b1;
            hold_valid_in = 1'b0;
         end else if (not_empty) begin
            out_in        = head.first;
            out_valid_in  = 1'b1;
            hold_in       = head.second;
            hold_valid_in = head.two;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      hold_ff <= hold_in;
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.token_kind   = out_ff.kind;
   assign rsp_bus.start_line   = out_ff.line;
   assign rsp_bus.start_column = out_ff.column;
   assign rsp_bus.token_length = out_ff.length;
   assign rsp_bus.number_value = out_ff.value;
   assign rsp_bus.last_of_run  = out_ff.last;

endmodule

/* hw/rtl/source_text_tokenizer_unit.sv */
// Top level of the streaming source text tokenizer
//
//   channel   direction  transfer carries
//   req_bus   in         one source byte, or the end marker
//   rsp_bus   out        one token: kind, start line/column, length, value, last flag
//
// A byte is taken every cycle while the group queue (4 entries) has room.
// A byte causing no token pushes nothing; one or two tokens share one queue entry and leave as separate transfers.
// First token of a byte passes through a queue entry and then the output register.
// Reset is synchronous; no clearing pass is needed.
// A stalled result side fills the queue, then req_bus.ready drops.
module source_text_tokenizer_unit (
   input  logic      clock,
   input  logic      reset,
   stt_req_if.sink   req_bus,
   stt_rsp_if.source rsp_bus
);
   import stt_pkg::*;

   push_type  push_grp;
   group_type head_grp;
   logic      q_full;
   logic      q_not_empty;
   logic      q_pop;

   stt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .q_full   (q_full),
      .push_out (push_grp)
   );

   stt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_in   (push_grp),
      .full      (q_full),
      .pop       (q_pop),
      .head      (head_grp),
      .not_empty (q_not_empty)
   );

   stt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head_grp),
      .not_empty (q_not_empty),
      .pop       (q_pop),
      .rsp_bus   (rsp_bus)
   );

endmodule

/* hw/rtl/stt_checker.sv */
// Port-level checks of the tokenizer, bound to the top level
`include "source_text_tokenizer_unit_assert.svh"

module stt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [stt_pkg::KIND_BITS-1:0]   rsp_token_kind,
   input logic [stt_pkg::LINE_BITS-1:0]   rsp_start_line,
   input logic [stt_pkg::COLUMN_BITS-1:0] rsp_start_column,
   input logic [stt_pkg::LEN_BITS-1:0]    rsp_token_length,
   input logic [stt_pkg::VALUE_BITS-1:0]  rsp_number_value,
   input logic                            rsp_last_of_run
);
   import stt_pkg::*;

   logic [KIND_BITS+LINE_BITS+COLUMN_BITS+LEN_BITS+VALUE_BITS:0] rsp_payload;
   logic rsp_stalled;
   logic rsp_is_end;
   logic end_shape_ok;
   logic rsp_not_number;
   logic value_is_zero;

   // Terms used by the checks
   assign rsp_payload    = {rsp_token_kind, rsp_start_line, rsp_start_column,
                            rsp_token_length, rsp_number_value, rsp_last_of_run};
   assign rsp_stalled    = rsp_valid && !rsp_ready;
   assign rsp_is_end     = rsp_valid && (rsp_token_kind == KIND_END);
   assign end_shape_ok   = (rsp_token_length == '0) && (rsp_number_value == '0)
                         && rsp_last_of_run;
   assign rsp_not_number = rsp_valid && (rsp_token_kind != KIND_NUMBER);
   assign value_is_zero  = (rsp_number_value == '0);

   // a stalled token stays offered
   `STT_ASSERT(a_rsp_hold, rsp_stalled |=> rsp_valid, "token dropped while stalled")

   // and unchanged
   `STT_ASSERT(a_rsp_stable, rsp_stalled |=> $stable(rsp_payload), "token changed while stalled")

   // nothing is offered straight after reset
   `STT_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "token offered after reset")

   // end token is empty and closes its run
   `STT_ASSERT(a_end_token, rsp_is_end |-> end_shape_ok, "malformed end token")

   // only number tokens carry a value
   `STT_ASSERT(a_value_zero, rsp_not_number |-> value_is_zero, "value on a non-number token")

endmodule

bind source_text_tokenizer_unit stt_checker u_stt_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_token_kind   (rsp_bus.token_kind),
   .rsp_start_line   (rsp_bus.start_line),
   .rsp_start_column (rsp_bus.start_column),
   .rsp_token_length (rsp_bus.token_length),
   .rsp_number_value (rsp_bus.number_value),
   .rsp_last_of_run  (rsp_bus.last_of_run)
);

/* tb/sv/tokenizer_checker.sv */
// Watches both channels of the tokenizer, predicts every token and compares it on arrival
module tokenizer_checker (
   input  logic        clock,
   input  logic        reset,
   stt_req_if          req_mon,
   stt_rsp_if          rsp_mon,
   output int          error_count,
   output int          pending_count,
   output int          token_count,
   output logic [28:0] kinds_seen
);
   import stt_pkg::*;

   // Scanner state as the predictor sees it
   mode_type                 scan_mode;
   logic [7:0]               held_op;
   logic [LINE_BITS-1:0]     line_now;
   logic [COLUMN_BITS-1:0]   col_now;
   logic [LINE_BITS-1:0]     tok_line;
   logic [COLUMN_BITS-1:0]   tok_col;
   logic [LEN_BITS-1:0]      lex_len;
   logic [VALUE_BITS-1:0]    num_acc;
   logic [KEYWORD_COUNT-1:0] kw_cand;
   bit                       text_ended;

   tok_type     step_toks[$];
   tok_type     expected_toks[$];
   int          failures = 0;
   int          compared = 0;
   logic [28:0] seen = '0;

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit is_blank(logic [7:0] c);
      return c == " " || (c >= 8'h09 && c <= 8'h0d);
   endfunction

   // Keep only the keywords whose spelling has c at position pos
   function automatic logic [KEYWORD_COUNT-1:0] narrow_keywords(
      logic [KEYWORD_COUNT-1:0] cand, int pos, logic [7:0] c);
      logic [KEYWORD_COUNT-1:0] keep;
      keep = '0;
      for (int k = 0; k < KEYWORD_COUNT; k++) begin
         if (cand[k] && pos < KW_LEN[k] && KW_TEXT[k][pos] == c) keep[k] = 1'b1;
      end
      return keep;
   endfunction

   task automatic add_token(logic [KIND_BITS-1:0] kind, logic [LINE_BITS-1:0] line,
                            logic [COLUMN_BITS-1:0] col, logic [LEN_BITS-1:0] len,
                            logic [VALUE_BITS-1:0] val);
      tok_type t;
      t.kind   = kind;
      t.line   = line;
      t.column = col;
      t.length = len;
      t.value  = val;
      t.last   = 1'b0;
      step_toks.push_back(t);
   endtask

   task automatic add_word();
      logic [KIND_BITS-1:0] kind;
      kind = KIND_IDENT;
      for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
         if (kw_cand[k] && LEN_BITS'(KW_LEN[k]) == lex_len) kind = KIND_FUNC + 5'(k);
      end
      add_token(kind, tok_line, tok_col, lex_len, '0);
   endtask

   task automatic add_single_op();
      logic [KIND_BITS-1:0] kind;
      case (held_op)
         "=":     kind = KIND_ASSIGN;
         "!":     kind = KIND_NOT;
         "<":     kind = KIND_LT;
         ">":     kind = KIND_GT;
         default: kind = KIND_ERROR;  // lone & or |
      endcase
      add_token(kind, tok_line, tok_col, 12'd1, '0);
   endtask

   // Close whatever token is still open
   task automatic close_token();
      case (scan_mode)
         MODE_NUMBER: add_token(KIND_NUMBER, tok_line, tok_col, lex_len, num_acc);
         MODE_IDENT:  add_word();
         MODE_SLASH:  add_token(KIND_DIV, tok_line, tok_col, 12'd1, '0);
         MODE_OPER:   add_single_op();
         default:     ;
      endcase
      scan_mode = MODE_IDLE;
   endtask

   task automatic open_token(logic [7:0] c, logic [LINE_BITS-1:0] line,
                             logic [COLUMN_BITS-1:0] col);
      logic [KIND_BITS-1:0] kind;
      kind      = KIND_ERROR;
      scan_mode = MODE_IDLE;
      if (is_blank(c)) return;
      tok_line = line;
      tok_col  = col;
      if (is_digit(c)) begin
         scan_mode = MODE_NUMBER;
         lex_len   = 12'd1;
         num_acc   = VALUE_BITS'(c - "0");
         return;
      end
      if (is_letter(c) || c == "_") begin
         scan_mode = MODE_IDENT;
         lex_len   = 12'd1;
         kw_cand   = narrow_keywords(KW_ALL, 0, c);
         return;
      end
      case (c)
         "/": begin
            scan_mode = MODE_SLASH;
            return;
         end
         "=", "!", "&", "|", "<", ">": begin
            scan_mode = MODE_OPER;
            held_op   = c;
            return;
         end
         "+":     kind = KIND_PLUS;
         "-":     kind = KIND_MINUS;
         "*":     kind = KIND_STAR;
         "(":     kind = KIND_LPAREN;
         ")":     kind = KIND_RPAREN;
         "{":     kind = KIND_LBRACE;
         "}":     kind = KIND_RBRACE;
         ";":     kind = KIND_SEMI;
         ",":     kind = KIND_COMMA;
         default: ;
      endcase
      add_token(kind, line, col, 12'd1, '0);
   endtask

   task automatic scan_char(logic [7:0] c, logic [LINE_BITS-1:0] line,
                            logic [COLUMN_BITS-1:0] col);
      logic [63:0]          wide;
      logic [KIND_BITS-1:0] kind;
      case (scan_mode)
         MODE_NUMBER: begin
            if (is_digit(c)) begin
               wide    = 64'(num_acc) * 10 + 64'(c - "0");
               num_acc = (wide > 64'hFFFF_FFFF) ? '1 : wide[31:0];
               if (lex_len != '1) lex_len++;
            end else begin
               close_token();
               open_token(c, line, col);
            end
         end
         MODE_IDENT: begin
            if (is_letter(c) || is_digit(c)) begin
               kw_cand = narrow_keywords(kw_cand, int'(lex_len), c);
               if (lex_len != '1) lex_len++;
            end else begin
               close_token();
               open_token(c, line, col);
            end
         end
         MODE_SLASH: begin
            if (c == "/") scan_mode = MODE_LINE;
            else if (c == "*") scan_mode = MODE_BLOCK;
            else begin
               close_token();
               open_token(c, line, col);
            end
         end
         MODE_LINE: begin
            if (c == 8'h0a) scan_mode = MODE_IDLE;
         end
         MODE_BLOCK, MODE_BLOCK_STAR: begin
            if (scan_mode == MODE_BLOCK_STAR && c == "/") scan_mode = MODE_IDLE;
            else if (c == "*") scan_mode = MODE_BLOCK_STAR;
            else scan_mode = MODE_BLOCK;
         end
         MODE_OPER: begin
            if ((c == "=" && (held_op == "=" || held_op == "!" || held_op == "<" ||
                              held_op == ">")) ||
                (c == "&" && held_op == "&") || (c == "|" && held_op == "|")) begin
               case (held_op)
                  "=":     kind = KIND_EQ;
                  "!":     kind = KIND_NE;
                  "&":     kind = KIND_ANDAND;
                  "|":     kind = KIND_OROR;
                  "<":     kind = KIND_LE;
                  default: kind = KIND_GE;
               endcase
               add_token(kind, tok_line, tok_col, 12'd2, '0);
               scan_mode = MODE_IDLE;
            end else begin
               close_token();
               open_token(c, line, col);
            end
         end
         default: open_token(c, line, col);
      endcase
   endtask

   // Tokens caused by one accepted transfer on the input channel
   task automatic predict_tokens(logic [7:0] c, logic eot);
      logic [LINE_BITS-1:0]   line;
      logic [COLUMN_BITS-1:0] col;
      line = line_now;
      col  = col_now;
      step_toks.delete();
      if (text_ended) return;
      if (eot) begin
         close_token();
         add_token(KIND_END, line, col, '0, '0);
         text_ended = 1'b1;
      end else begin
         scan_char(c, line, col);
         if (c == 8'h0a) begin
            if (line_now != '1) line_now++;
            col_now = '0;
         end else if (col_now != '1) begin
            col_now++;
         end
      end
      if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
      foreach (step_toks[i]) expected_toks.push_back(step_toks[i]);
   endtask

   // Compare one token that left the block with the oldest prediction
   task automatic check_token();
      tok_type got;
      tok_type want;
      got.kind   = rsp_mon.token_kind;
      got.line   = rsp_mon.start_line;
      got.column = rsp_mon.start_column;
      got.length = rsp_mon.token_length;
      got.value  = rsp_mon.number_value;
      got.last   = rsp_mon.last_of_run;
      compared++;
      if (got.kind <= KIND_END) seen[got.kind] = 1'b1;
      if (expected_toks.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("MISMATCH: token kind %0d line %0d col %0d len %0d value %0d last %0b %s",
                     got.kind, got.line, got.column, got.length, got.value, got.last,
                     "arrived with nothing expected");
         return;
      end
      want = expected_toks.pop_front();
      if (got.kind !== want.kind || got.line !== want.line || got.column !== want.column ||
          got.length !== want.length || got.value !== want.value || got.last !== want.last)
      begin
         failures++;
         if (failures <= 10) begin
            $display("MISMATCH: expected kind %0d line %0d col %0d len %0d value %0d last %0b",
                     want.kind, want.line, want.column, want.length, want.value, want.last);
            $display("          got      kind %0d line %0d col %0d len %0d value %0d last %0b",
                     got.kind, got.line, got.column, got.length, got.value, got.last);
         end
      end
   endtask

   // Sample both channels at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         scan_mode  = MODE_IDLE;
         held_op    = '0;
         line_now   = '0;
         col_now    = 12'd1;
         tok_line   = '0;
         tok_col    = '0;
         lex_len    = '0;
         num_acc    = '0;
         kw_cand    = KW_ALL;
         text_ended = 1'b0;
         expected_toks.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            predict_tokens(req_mon.char_byte, req_mon.end_of_text);
         if (rsp_mon.valid && rsp_mon.ready) check_token();
      end
      error_count   <= failures;
      pending_count <= expected_toks.size();
      token_count   <= compared;
      kinds_seen    <= seen;
   end

endmodule

/* tb/sv/tb_top.sv */
// Top of the tokenizer testbench: clock, reset, source text stimulus and verdict
module tb_top;

   localparam logic [7:0] BLANKS [6] = '{8'h20, 8'h09, 8'h0a, 8'h0d, 8'h0b, 8'h0c};
   localparam int LONG_HOLD = 200;

   logic        clock;
   logic        reset;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          stall_requests = 0;
   int          stall_served = 0;
   int          stall_left = 0;
   int          bytes_sent = 0;
   int          errors;
   int          pending;
   int          tokens;
   logic [28:0] kinds;
   string       single_ops = "+-*/(){};,=!<>&|";

   stt_req_if req_bus ();
   stt_rsp_if rsp_bus ();

   source_text_tokenizer_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   tokenizer_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .error_count   (errors),
      .pending_count (pending),
      .token_count   (tokens),
      .kinds_seen    (kinds)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Result side: random stalls, plus a long hold-off whenever one is asked for
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else if (stall_served != stall_requests) begin
         rsp_bus.ready <= 1'b0;
         stall_served  <= stall_requests;
         stall_left    <= LONG_HOLD;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   function automatic string keyword_text(int k);
      case (k)
         0:       return "func";
         1:       return "if";
         2:       return "else";
         3:       return "while";
         default: return "return";
      endcase
   endfunction

   function automatic string double_op(int k);
      case (k)
         0:       return "==";
         1:       return "!=";
         2:       return "&&";
         3:       return "||";
         4:       return "<=";
         default: return ">=";
      endcase
   endfunction

   // Awkward neighbours: glued tokens, triple operators, empty comments
   function automatic string awkward_text(int k);
      case (k)
         0:       return "12ab";
         1:       return "a_b";
         2:       return "x/y";
         3:       return "<<=";
         4:       return "&&&";
         5:       return "!==";
         6:       return "if_else";
         7:       return "a/**/b";
         8:       return "|&";
         default: return "=>";
      endcase
   endfunction

   function automatic logic [7:0] random_alnum(bit letters_only);
      int r;
      r = letters_only ? $urandom_range(51) : $urandom_range(61);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      return 8'("0" + r - 52);
   endfunction

   // One transfer on the input channel, after a random gap
   task automatic send_byte(input logic [7:0] c, input bit eot);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.char_byte   <= c;
      req_bus.end_of_text <= eot;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
   endtask

   // A lexeme or short run of lexemes with random content, some of them awkward
   task automatic send_word();
      string w;
      int    n;
      int    k;
      case ($urandom_range(6))
         0: send_text(keyword_text($urandom_range(4)));
         1: begin
            w = keyword_text($urandom_range(4));
            case ($urandom_range(2))
               0: send_text(w.substr(0, w.len() - 2));
               1: begin
                  send_text(w);
                  send_byte(random_alnum(1'b0), 1'b0);
               end
               default: begin
                  send_byte("_", 1'b0);
                  send_text(w);
               end
            endcase
         end
         2: begin
            send_byte(($urandom_range(3) == 0) ? 8'h5f : random_alnum(1'b1), 1'b0);
            n = $urandom_range(6);
            repeat (n) send_byte(random_alnum(1'b0), 1'b0);
         end
         3: begin
            if ($urandom_range(7) == 0) begin
               // around the 32-bit saturation point
               case ($urandom_range(2))
                  0:       send_text("4294967295");
                  1:       send_text("4294967296");
                  default: send_text("99999999999");
               endcase
            end else begin
               n = $urandom_range(1, 4);
               repeat (n) send_byte(8'("0" + $urandom_range(9)), 1'b0);
            end
         end
         4: begin
            k = $urandom_range(single_ops.len() - 1);
            send_byte(single_ops[k], 1'b0);
         end
         5: send_text(double_op($urandom_range(5)));
         default: send_text(awkward_text($urandom_range(9)));
      endcase
   endtask

   task automatic send_comment();
      int n;
      n = $urandom_range(8);
      if ($urandom_range(1)) begin
         send_text("//");
         repeat (n) send_byte(8'($urandom_range(32, 126)), 1'b0);
         send_byte(8'h0a, 1'b0);
      end else begin
         send_text("/*");
         // a slash straight after the opener must not close the comment
         if ($urandom_range(3) == 0) send_byte("/", 1'b0);
         repeat (n) begin
            case ($urandom_range(4))
               0:       send_byte("*", 1'b0);
               1:       send_byte(8'h0a, 1'b0);
               2:       send_byte(8'($urandom_range(255)), 1'b0);
               default: send_byte(random_alnum(1'b0), 1'b0);
            endcase
         end
         send_text("*/");
      end
   endtask

   task automatic send_noise();
      case ($urandom_range(3))
         0: begin
            send_byte("&", 1'b0);
            send_word();
         end
         1: begin
            send_byte("|", 1'b0);
            send_word();
         end
         default: send_byte(8'($urandom_range(255)), 1'b0);
      endcase
   endtask

   task automatic send_fragment();
      int r;
      r = $urandom_range(99);
      if (r < 70) begin
         send_word();
         if ($urandom_range(9) < 6) send_byte(BLANKS[$urandom_range(5)], 1'b0);
      end else if (r < 85) begin
         send_comment();
      end else begin
         send_noise();
      end
   endtask

   // Stimulus
   initial begin
      int target;
      int waited;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.char_byte   = '0;
      req_bus.end_of_text = 1'b0;
      rsp_bus.ready       = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: lone & and |, underscore after identifier, digit then letter,
      // slash as divide, block comment whose opening star does not count
      send_text("x_1&|/2a/*/*/");
      send_byte(8'h0a, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_text("==!=&&||<=>=");

      // Random text in four idling phases
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct <= 0;
               stall_requests <= stall_requests + 1;  // block fills and stalls input
            end
            1: begin
               send_idle_pct = 85;
               rsp_stall_pct <= 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct <= 85;
            end
            default: begin
               send_idle_pct = 21;
               rsp_stall_pct <= 21;
            end
         endcase
         target = bytes_sent + 205;
         while (bytes_sent < target) send_fragment();
      end

      // Numbers at and beyond the 32-bit limit
      send_idle_pct = 0;
      rsp_stall_pct <= 0;
      send_text(" 4294967295 4294967296 12345678901234");
      send_byte(8'h0a, 1'b0);

      // End of text inside an open comment, then transfers that must be ignored
      send_text("/* never closed");
      send_byte(8'($urandom_range(255)), 1'b1);
      repeat (5) send_byte(8'($urandom_range(255)), 1'b0);
      send_byte(8'($urandom_range(255)), 1'b1);
      req_bus.valid <= 1'b0;

      // Drain
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (pending != 0 && waited < 20000);
      repeat (10) @(posedge clock);

      $display("Summary: %0d bytes over four idling phases and a long stall, %0d tokens",
               bytes_sent, tokens);
      $display("compared, %0d of 29 token kinds seen, %0d mismatches, %0d tokens missing",
               $countones(kinds), errors, pending);
      if (errors == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
